[design/adsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope package
// Word types, register indexes, stage codes and sequencer states shared by
// the envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Q1.15 level format
  localparam int              FRAC_BITS  = 15;
  localparam int              LEVEL_W    = 16;
  localparam logic [15:0]     FULL_SCALE = 16'h8000;
  localparam logic [16:0]     THREE_FULL = 17'd98304;

  // request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
  localparam logic [1:0] REQ_RESET    = 2'd3;

  // envelope stage codes
  localparam logic [2:0] STG_IDLE    = 3'd0;
  localparam logic [2:0] STG_ATTACK  = 3'd1;
  localparam logic [2:0] STG_DECAY   = 3'd2;
  localparam logic [2:0] STG_SUSTAIN = 3'd3;
  localparam logic [2:0] STG_RELEASE = 3'd4;

  // configuration register indexes
  localparam int         CFG_IDX_W       = 2;
  localparam logic [1:0] CFG_ATTACK_LEN  = 2'd0;
  localparam logic [1:0] CFG_DECAY_LEN   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN_LVL = 2'd2;
  localparam logic [1:0] CFG_RELEASE_LEN = 2'd3;

  // register reset values
  localparam int          ATTACK_LEN_RST  = 441;
  localparam int          DECAY_LEN_RST   = 4410;
  localparam logic [15:0] SUSTAIN_LVL_RST = 16'd22938;
  localparam int          RELEASE_LEN_RST = 8820;

  // shift-subtract divider: one quotient bit per cycle
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [15:0] audio_in;
  } adsr_in_t;

  typedef struct packed {
    logic        [15:0] env_value;
    logic signed [15:0] scaled_out;
    logic        [2:0]  stage_after;
  } adsr_out_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ATK_DIV  = 10'b00_0000_0010,
    S_ATK_SQ   = 10'b00_0000_0100,
    S_ATK_CUBE = 10'b00_0000_1000,
    S_ATK_MIX  = 10'b00_0001_0000,
    S_ATK_SUM  = 10'b00_0010_0000,
    S_LIN_MUL  = 10'b00_0100_0000,
    S_LIN_DIV  = 10'b00_1000_0000,
    S_SCALE    = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } adsr_fsm_t;

endpackage
`default_nettype wire

[design/adsr_envelope_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Attack (smoothstep), decay, sustain and release envelope in Q1.15 that
// scales one audio sample per tick word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : valid/ready words carrying a request code and an audio sample.
//            Note-on, note-off and reset words update the envelope state in
//            the cycle they are taken and give no result; the next word may
//            follow in the following cycle.
//   out_*  : valid/ready words with the envelope level, the scaled sample and
//            the stage after the tick. One result per tick word.
//   cfg_*  : write-only register port, written while the block is idle.
//   A tick in idle or sustain, in a one-sample attack and at the last sample
//   of decay or release only scales the sample. In decay or release the shared
//   multiplier forms the product, the shift-subtract divider divides it, then
//   the sample is scaled; in attack the divider runs first and the multiplier
//   is used up to four times. in_ready is low while a tick is in progress.
//   A finished result waits in the output register; the block takes new
//   words meanwhile and only stalls when the next result is ready and the
//   output register is still full.
//   Synchronous reset returns the envelope to idle at level zero and loads
//   the register defaults.
// ----------------------------------------------------------------------------
module adsr_envelope_generator #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  adsr_pkg::adsr_in_t                               in_data,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output adsr_pkg::adsr_out_t                              out_data,
  input  logic                                             cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]                   cfg_index,
  input  logic [((LENGTH_BITS > 16) ? LENGTH_BITS : 16)-1:0] cfg_wdata
);
  import adsr_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int MB = ((LB > 17) ? LB : 17) + 1;
  localparam int PW = 18 + MB;
  localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
  localparam logic signed [PW-1:0] SAT_LO = PW'(-32768);

  // configuration
  logic [LB-1:0]      atk_len_r, atk_len_nxt;
  logic [LB-1:0]      dec_len_r, dec_len_nxt;
  logic [LB-1:0]      rel_len_r, rel_len_nxt;
  logic [15:0]        sus_lvl_r, sus_lvl_nxt;

  // envelope state
  logic [2:0]         stage_r, stage_nxt;
  logic [15:0]        level_r, level_nxt;
  logic [LB-1:0]      count_r, count_nxt;
  logic [15:0]        rel_start_r, rel_start_nxt;
  logic [15:0]        atk_start_r, atk_start_nxt;

  // sequencer and output
  adsr_fsm_t          fsm_r, fsm_nxt;
  logic               out_valid_r, out_valid_nxt;
  adsr_out_t          out_data_r, out_data_nxt;

  // working registers
  logic signed [15:0] audio_r, audio_nxt;
  logic [LB-1:0]      len_r, len_nxt;
  logic [LB-1:0]      cc_r, cc_nxt;
  logic               lin_decay_r, lin_decay_nxt;
  logic [15:0]        p_r, p_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [LB-1:0]      rem_r, rem_nxt;
  logic [15:0]        dlo_r, dlo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // combinational helpers
  logic                 in_fire;
  logic [LB-1:0]        cur_len;
  logic [LB-1:0]        cc_now;
  logic [LB:0]          cnt_inc;
  logic                 at_end;
  logic [15:0]          sus_eff;
  logic signed [17:0]   mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic [LB:0]          rem_sh;
  logic [LB:0]          div_diff;
  logic                 div_ge;
  logic [LB-1:0]        div_rem;
  logic [15:0]          div_quo;
  logic                 div_last;
  logic [16:0]          atk_t;
  logic signed [PW-1:0] scale_shift;
  logic signed [15:0]   scaled_sat;

  assign in_ready  = (fsm_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sus_eff = (sus_lvl_r > FULL_SCALE) ? FULL_SCALE : sus_lvl_r;

  // length of the running stage; a zero length acts as one
  always_comb begin
    case (stage_r)
      STG_ATTACK:  cur_len = (atk_len_r == '0) ? LB'(1) : atk_len_r;
      STG_DECAY:   cur_len = (dec_len_r == '0) ? LB'(1) : dec_len_r;
      STG_RELEASE: cur_len = (rel_len_r == '0) ? LB'(1) : rel_len_r;
      default:     cur_len = LB'(1);
    endcase
  end

  assign cc_now  = (count_r > cur_len) ? cur_len : count_r;
  assign cnt_inc = {1'b0, count_r} + (LB+1)'(1);
  assign at_end  = (cnt_inc >= {1'b0, cur_len});

  // shared multiplier operand selection
  assign atk_t = THREE_FULL - {p_r, 1'b0};

  always_comb begin
    case (fsm_r)
      S_ATK_SQ: begin
        mul_a = {2'b00, p_r};
        mul_b = MB'(p_r);
      end
      S_ATK_CUBE: begin
        mul_a = {2'b00, prod_r[FRAC_BITS +: LEVEL_W]};
        mul_b = MB'(atk_t);
      end
      S_ATK_MIX: begin
        mul_a = {2'b00, FULL_SCALE - atk_start_r};
        mul_b = MB'(prod_r[FRAC_BITS +: LEVEL_W]);
      end
      S_LIN_MUL: begin
        if (lin_decay_r) begin
          mul_a = {2'b00, FULL_SCALE - sus_eff};
          mul_b = MB'(cc_r);
        end else begin
          mul_a = {2'b00, rel_start_r};
          mul_b = MB'(len_r - cc_r);
        end
      end
      S_SCALE: begin
        mul_a = {{2{audio_r[15]}}, audio_r};
        mul_b = MB'(level_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // one restoring divide step a cycle
  assign rem_sh   = {rem_r, dlo_r[15]};
  assign div_diff = rem_sh - {1'b0, len_r};
  assign div_ge   = !div_diff[LB];
  assign div_rem  = div_ge ? div_diff[LB-1:0] : rem_sh[LB-1:0];
  assign div_quo  = {dlo_r[14:0], div_ge};
  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // floor of the scaled sample, then saturate
  assign scale_shift = prod_r >>> FRAC_BITS;
  always_comb begin
    if (scale_shift > SAT_HI) begin
      scaled_sat = 16'sh7fff;
    end else if (scale_shift < SAT_LO) begin
      scaled_sat = -16'sh8000;
    end else begin
      scaled_sat = scale_shift[15:0];
    end
  end

  always_comb begin
    atk_len_nxt   = atk_len_r;
    dec_len_nxt   = dec_len_r;
    rel_len_nxt   = rel_len_r;
    sus_lvl_nxt   = sus_lvl_r;
    stage_nxt     = stage_r;
    level_nxt     = level_r;
    count_nxt     = count_r;
    rel_start_nxt = rel_start_r;
    atk_start_nxt = atk_start_r;
    fsm_nxt       = fsm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    audio_nxt     = audio_r;
    len_nxt       = len_r;
    cc_nxt        = cc_r;
    lin_decay_nxt = lin_decay_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dlo_nxt       = dlo_r;
    div_cnt_nxt   = div_cnt_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_LEN:  atk_len_nxt = cfg_wdata[LB-1:0];
        CFG_DECAY_LEN:   dec_len_nxt = cfg_wdata[LB-1:0];
        CFG_SUSTAIN_LVL: sus_lvl_nxt = cfg_wdata[15:0];
        CFG_RELEASE_LEN: rel_len_nxt = cfg_wdata[LB-1:0];
        default: ;
      endcase
    end

    case (fsm_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.req_type)
            REQ_NOTE_ON: begin
              stage_nxt     = STG_ATTACK;
              count_nxt     = '0;
              atk_start_nxt = level_r;
            end
            REQ_NOTE_OFF: begin
              if (stage_r != STG_IDLE) begin
                stage_nxt     = STG_RELEASE;
                count_nxt     = '0;
                rel_start_nxt = level_r;
              end
            end
            REQ_RESET: begin
              stage_nxt = STG_IDLE;
              level_nxt = '0;
              count_nxt = '0;
            end
            REQ_TICK: begin
              audio_nxt = in_data.audio_in;
              len_nxt   = cur_len;
              cc_nxt    = cc_now;
              fsm_nxt   = S_SCALE;
              case (stage_r)
                STG_ATTACK: begin
                  if (at_end) begin
                    stage_nxt = STG_DECAY;
                    count_nxt = '0;
                  end else begin
                    count_nxt = cnt_inc[LB-1:0];
                  end
                  if (cur_len == LB'(1)) begin
                    level_nxt = FULL_SCALE;
                  end else begin
                    // p = c * FULL / L, remainder starts below L
                    rem_nxt     = cc_now >> 1;
                    dlo_nxt     = {cc_now[0], 15'd0};
                    div_cnt_nxt = '0;
                    fsm_nxt     = S_ATK_DIV;
                  end
                end
                STG_DECAY: begin
                  if (at_end) begin
                    stage_nxt = STG_SUSTAIN;
                    count_nxt = '0;
                    level_nxt = sus_eff;
                  end else begin
                    count_nxt     = cnt_inc[LB-1:0];
                    lin_decay_nxt = 1'b1;
                    fsm_nxt       = S_LIN_MUL;
                  end
                end
                STG_RELEASE: begin
                  if (at_end) begin
                    stage_nxt = STG_IDLE;
                    count_nxt = '0;
                    level_nxt = '0;
                  end else begin
                    count_nxt     = cnt_inc[LB-1:0];
                    lin_decay_nxt = 1'b0;
                    fsm_nxt       = S_LIN_MUL;
                  end
                end
                STG_SUSTAIN: begin
                  level_nxt = sus_eff;
                  count_nxt = '0;
                end
                default: begin
                  stage_nxt = STG_IDLE;
                  level_nxt = '0;
                  count_nxt = '0;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      S_ATK_DIV: begin
        rem_nxt     = div_rem;
        dlo_nxt     = div_quo;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          p_nxt   = div_quo;
          fsm_nxt = S_ATK_SQ;
        end
      end
      S_ATK_SQ: begin
        prod_nxt = mul_p;
        fsm_nxt  = S_ATK_CUBE;
      end
      S_ATK_CUBE: begin
        prod_nxt = mul_p;
        fsm_nxt  = S_ATK_MIX;
      end
      S_ATK_MIX: begin
        prod_nxt = mul_p;
        fsm_nxt  = S_ATK_SUM;
      end
      S_ATK_SUM: begin
        level_nxt = atk_start_r + prod_r[FRAC_BITS +: LEVEL_W];
        fsm_nxt   = S_SCALE;
      end
      S_LIN_MUL: begin
        // load the product straight into the divider
        rem_nxt     = mul_p[LB+15:16];
        dlo_nxt     = mul_p[15:0];
        div_cnt_nxt = '0;
        fsm_nxt     = S_LIN_DIV;
      end
      S_LIN_DIV: begin
        rem_nxt     = div_rem;
        dlo_nxt     = div_quo;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          level_nxt = lin_decay_r ? (FULL_SCALE - div_quo) : div_quo;
          fsm_nxt   = S_SCALE;
        end
      end
      S_SCALE: begin
        prod_nxt = mul_p;
        fsm_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.env_value   = level_r;
          out_data_nxt.scaled_out  = scaled_sat;
          out_data_nxt.stage_after = stage_r;
          fsm_nxt                  = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_len_r   <= LB'(ATTACK_LEN_RST);
      dec_len_r   <= LB'(DECAY_LEN_RST);
      rel_len_r   <= LB'(RELEASE_LEN_RST);
      sus_lvl_r   <= SUSTAIN_LVL_RST;
      stage_r     <= STG_IDLE;
      level_r     <= '0;
      count_r     <= '0;
      rel_start_r <= '0;
      atk_start_r <= '0;
      fsm_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      atk_len_r   <= atk_len_nxt;
      dec_len_r   <= dec_len_nxt;
      rel_len_r   <= rel_len_nxt;
      sus_lvl_r   <= sus_lvl_nxt;
      stage_r     <= stage_nxt;
      level_r     <= level_nxt;
      count_r     <= count_nxt;
      rel_start_r <= rel_start_nxt;
      atk_start_r <= atk_start_nxt;
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    audio_r     <= audio_nxt;
    len_r       <= len_nxt;
    cc_r        <= cc_nxt;
    lin_decay_r <= lin_decay_nxt;
    p_r         <= p_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    dlo_r       <= dlo_nxt;
    div_cnt_r   <= div_cnt_nxt;
  end

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_SCALE)
    else $error("envelope level above full scale");

  a_stage_code: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= STG_RELEASE)
    else $error("envelope stage code out of range");

  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_ATK_DIV || fsm_r == S_LIN_DIV) |-> (rem_r < len_r))
    else $error("divider remainder not below divisor");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fsm_r == S_OUT))
    else $error("result raised outside the output step");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == REQ_TICK) |=> (fsm_r != S_IDLE))
    else $error("tick word did not start the sequencer");

endmodule
`default_nettype wire

[sim/adsr_envelope_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Sends request words (tick, note-on, note-off, reset) through the valid/ready
// input, predicts every tick result with a cycle-free envelope model and
// checks each result word field by field. The registers are rewritten between
// phases while the block is quiet, and both sides idle in random bursts.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_tb;
  import adsr_pkg::*;

  localparam int              WATCHDOG_LIMIT = 1000;
  localparam int              SETTLE_CYCLES  = 30;
  localparam int              RANDOM_WORDS   = 1200;
  localparam int              CALM_WORDS     = 150;
  localparam int              REPORT_MAX     = 10;
  localparam int              SPAN_MAX       = 48;
  localparam longint unsigned UNITY          = 64'(FULL_SCALE);

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  adsr_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  adsr_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [19:0]          cfg_wdata = '0;

  // envelope state and register copies
  logic [2:0]      env_stage = STG_IDLE;
  longint unsigned env_level = 0;
  longint unsigned env_count = 0;
  longint unsigned atk_start = 0;
  longint unsigned rel_start = 0;
  longint unsigned atk_len   = ATTACK_LEN_RST;
  longint unsigned dec_len   = DECAY_LEN_RST;
  longint unsigned sus_lvl   = SUSTAIN_LVL_RST;
  longint unsigned rel_len   = RELEASE_LEN_RST;

  adsr_in_t  words_to_send[$];
  adsr_out_t expected_results[$];

  int words_queued    = 0;
  int words_accepted  = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int cfg_writes      = 0;
  int n_ticks         = 0;
  int n_note_on       = 0;
  int n_note_off      = 0;
  int n_resets        = 0;
  int idle_cycles     = 0;
  int send_gap        = 0;
  int stall_left      = 0;
  bit quiet           = 1'b0;
  bit in_taken        = 1'b0;
  bit out_taken       = 1'b0;

  adsr_envelope_generator #(
    .LENGTH_BITS(20)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the envelope by one request word; returns 1 when a result is due.
  function automatic bit envelope_step(input adsr_in_t w, output adsr_out_t r);
    longint unsigned len, c, cc, sus, p, q, s, a, rs, lvl;
    longint          prod;
    r = '0;
    case (w.req_type)
      REQ_NOTE_ON: begin
        env_stage = STG_ATTACK;
        env_count = 0;
        atk_start = env_level;
        return 1'b0;
      end
      REQ_NOTE_OFF: begin
        if (env_stage != STG_IDLE) begin
          env_stage = STG_RELEASE;
          env_count = 0;
          rel_start = env_level;
        end
        return 1'b0;
      end
      REQ_RESET: begin
        env_stage = STG_IDLE;
        env_level = 0;
        env_count = 0;
        return 1'b0;
      end
      default: ;
    endcase

    sus = (sus_lvl > UNITY) ? UNITY : sus_lvl;
    c   = env_count;
    lvl = 0;
    case (env_stage)
      STG_ATTACK: begin
        len = (atk_len == 0) ? 1 : atk_len;
        if (len <= 1) begin
          lvl = UNITY;
        end else begin
          cc  = (c > len) ? len : c;
          p   = (cc << FRAC_BITS) / len;
          q   = (p * p) >> FRAC_BITS;
          s   = (q * (3 * UNITY - 2 * p)) >> FRAC_BITS;
          a   = (atk_start > UNITY) ? UNITY : atk_start;
          lvl = a + (((UNITY - a) * s) >> FRAC_BITS);
        end
        if (c + 1 >= len) begin
          env_stage = STG_DECAY;
          env_count = 0;
        end else begin
          env_count = c + 1;
        end
      end
      STG_DECAY: begin
        len = (dec_len == 0) ? 1 : dec_len;
        cc  = (c > len) ? len : c;
        lvl = (len <= 1) ? sus : UNITY - ((UNITY - sus) * cc) / len;
        if (c + 1 >= len) begin
          env_stage = STG_SUSTAIN;
          env_count = 0;
          lvl       = sus;
        end else begin
          env_count = c + 1;
        end
      end
      STG_SUSTAIN: begin
        lvl       = sus;
        env_count = 0;
      end
      STG_RELEASE: begin
        len = (rel_len == 0) ? 1 : rel_len;
        cc  = (c > len) ? len : c;
        rs  = (rel_start > UNITY) ? UNITY : rel_start;
        lvl = (len <= 1) ? 0 : (rs * (len - cc)) / len;
        if (c + 1 >= len) begin
          env_stage = STG_IDLE;
          env_count = 0;
          lvl       = 0;
        end else begin
          env_count = c + 1;
        end
      end
      default: begin
        env_stage = STG_IDLE;
        env_count = 0;
      end
    endcase
    env_level = lvl;

    // floor of the signed product, then clip to the sample range
    prod = (longint'(w.audio_in) * longint'(env_level)) >>> FRAC_BITS;
    if (prod > 32767)  prod = 32767;
    if (prod < -32768) prod = -32768;

    r.env_value   = env_level[15:0];
    r.scaled_out  = prod[15:0];
    r.stage_after = env_stage;
    return 1'b1;
  endfunction

  task automatic flag_result(input string why, input adsr_out_t want, input adsr_out_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] %s: env %0d/%0d out %0d/%0d stage %0d/%0d (expected/actual)",
               $time, why, want.env_value, got.env_value, want.scaled_out, got.scaled_out,
               want.stage_after, got.stage_after);
    end
  endtask

  // driver: present the next word at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        in_data  <= words_to_send.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results, predict accepted words, watch for a hang
  always @(posedge clk) begin : monitor_blk
    adsr_out_t want;
    adsr_out_t predicted;
    in_taken  = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;

    if (out_taken) begin
      if (expected_results.size() == 0) begin
        flag_result("result with nothing expected", '0, out_data);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.env_value !== want.env_value || out_data.scaled_out !== want.scaled_out ||
            out_data.stage_after !== want.stage_after) begin
          flag_result("result mismatch", want, out_data);
        end
      end
    end

    if (in_taken) begin
      words_accepted++;
      if (envelope_step(in_data, predicted)) expected_results.push_back(predicted);
    end

    if (in_taken || out_taken || cfg_we || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] req, input logic [15:0] audio);
    adsr_in_t w;
    w.req_type = req;
    w.audio_in = audio;
    words_to_send.push_back(w);
    words_queued++;
    case (req)
      REQ_TICK:     n_ticks++;
      REQ_NOTE_ON:  n_note_on++;
      REQ_NOTE_OFF: n_note_off++;
      default:      n_resets++;
    endcase
  endtask

  function automatic logic [15:0] random_audio();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_ticks(input int n);
    repeat (n) push_word(REQ_TICK, random_audio());
  endtask

  function automatic int tick_span(input longint unsigned n);
    return $urandom_range(0, (n > SPAN_MAX) ? SPAN_MAX : int'(n));
  endfunction

  function automatic logic [19:0] pick_length();
    case ($urandom_range(0, 15))
      0:       return 20'd0;
      1:       return 20'd1;
      2:       return 20'hFFFFF;
      3:       return 20'($urandom_range(1, 1048575));
      default: return 20'($urandom_range(2, 20));
    endcase
  endfunction

  function automatic logic [19:0] pick_sustain();
    case ($urandom_range(0, 9))
      0:       return 20'd0;
      1:       return 20'd32768;
      2:       return 20'($urandom_range(32769, 65535));
      default: return 20'($urandom_range(0, 32768));
    endcase
  endfunction

  // hold until every word is taken and every result is back, then let it settle
  task automatic wait_idle();
    do @(negedge clk);
    while (words_accepted != words_queued || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      CFG_ATTACK_LEN:  atk_len = value;
      CFG_DECAY_LEN:   dec_len = value;
      CFG_SUSTAIN_LVL: sus_lvl = value[15:0];
      default:         rel_len = value;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [19:0] atk, input logic [19:0] dec,
                          input logic [19:0] sus, input logic [19:0] rel);
    write_reg(CFG_ATTACK_LEN, atk);
    write_reg(CFG_DECAY_LEN, dec);
    write_reg(CFG_SUSTAIN_LVL, sus);
    write_reg(CFG_RELEASE_LEN, rel);
  endtask

  // mostly whole notes with random content, some stray and broken sequences
  task automatic random_phase(input int target);
    while (words_queued < target) begin
      case ($urandom_range(0, 9))
        0: push_word(2'($urandom_range(0, 3)), random_audio());
        1: begin
          push_word(REQ_RESET, random_audio());
          push_ticks($urandom_range(0, 3));
        end
        2: begin
          push_word(REQ_NOTE_OFF, random_audio());
          push_ticks(tick_span(rel_len + 2));
        end
        default: begin
          push_word(REQ_NOTE_ON, random_audio());
          push_ticks(tick_span(atk_len + dec_len + 3));
          if ($urandom_range(0, 4) != 0) begin
            push_word(REQ_NOTE_OFF, random_audio());
            push_ticks(tick_span(rel_len + 2));
          end
        end
      endcase
    end
  endtask

  initial begin : sequencer
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // register defaults: idle tick, note-off while idle, start of an attack
    push_word(REQ_TICK, 16'h7FFF);
    push_word(REQ_NOTE_OFF, 16'h1234);
    push_word(REQ_NOTE_ON, 16'h0000);
    push_word(REQ_TICK, 16'h8000);
    push_word(REQ_TICK, 16'h7FFF);
    push_word(REQ_TICK, 16'hFFFF);
    wait_idle();

    // attack shrunk below the count, long decay, sustain above full scale
    set_regs(20'd2, 20'hFFFFF, 20'd65535, 20'hFFFFF);
    push_word(REQ_TICK, 16'h4000);
    push_word(REQ_TICK, 16'h8000);
    push_word(REQ_NOTE_OFF, 16'h0000);
    push_word(REQ_TICK, 16'h7FFF);
    push_word(REQ_TICK, 16'h8000);
    push_word(REQ_NOTE_ON, 16'h0000);
    push_word(REQ_TICK, 16'hC000);
    wait_idle();

    // zero lengths act as one sample, sustain at zero
    set_regs(20'd0, 20'd0, 20'd0, 20'd0);
    push_word(REQ_TICK, 16'h7FFF);
    push_word(REQ_TICK, 16'h8000);
    push_word(REQ_TICK, 16'h5555);
    push_word(REQ_NOTE_OFF, 16'h0000);
    push_word(REQ_TICK, 16'hAAAA);
    push_word(REQ_RESET, 16'hFFFF);
    push_word(REQ_TICK, 16'h7FFF);
    wait_idle();

    // longest attack, one-sample decay and release, full-scale sustain
    set_regs(20'hFFFFF, 20'd1, 20'd32768, 20'd1);
    push_word(REQ_NOTE_ON, 16'h0001);
    push_word(REQ_TICK, 16'h8000);
    push_word(REQ_TICK, 16'h7FFF);
    push_word(REQ_RESET, 16'h0000);
    wait_idle();

    while (words_queued < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) write_reg(CFG_ATTACK_LEN, pick_length());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_DECAY_LEN, pick_length());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_SUSTAIN_LVL, pick_sustain());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_RELEASE_LEN, pick_length());
      random_phase(words_queued + $urandom_range(40, 100));
      wait_idle();
    end

    // closing stretch at full rate on both sides
    set_regs(20'($urandom_range(1, 12)), 20'($urandom_range(1, 12)),
             pick_sustain(), 20'($urandom_range(1, 12)));
    quiet = 1'b1;
    random_phase(words_queued + CALM_WORDS);
    wait_idle();

    $display("sent %0d words: %0d ticks, %0d note-on, %0d note-off, %0d resets; %0d reg writes",
             words_queued, n_ticks, n_note_on, n_note_off, n_resets, cfg_writes);
    $display("checked %0d envelope results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/adsr_pkg.sv
design/adsr_envelope_generator.sv
sim/adsr_envelope_generator_tb.sv
